>>> hw/rtl/dpsi_pkg.sv
// ----------------------------------------------------------------------------
// dpsi_pkg
// Shared types and constants for the dual pump safety interlock.
// ----------------------------------------------------------------------------
package dpsi_pkg;

	localparam int TIMER_BITS_DEF = 24;
	localparam int CFG_W          = 24;
	localparam int ACT_W          = 3;
	localparam int PADDR_W        = 4;
	localparam int PDATA_W        = 32;

	// event codes
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ACID  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_BASE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_STOP  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ESTOP = 3'd4;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_PUMP_MAX  = 2'd0;
	localparam logic [1:0] REG_COOLDOWN  = 2'd1;
	localparam logic [1:0] REG_OVERRIDE  = 2'd2;
	localparam logic [1:0] REG_RELAY_POL = 2'd3;

	localparam logic [CFG_W-1:0] PUMP_MAX_RST = 24'd60000;
	localparam logic [CFG_W-1:0] COOLDOWN_RST = 24'd30000;
	localparam logic [CFG_W-1:0] OVERRIDE_RST = 24'd300000;
	localparam logic             RELAY_POL_RST = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] pump_max_ticks;
		logic [CFG_W-1:0] cooldown_ticks;
		logic [CFG_W-1:0] override_ticks;
		logic             relay_active_low;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             turn_on;
		logic             is_manual;
	} item_t;

	typedef struct packed {
		logic             acid_drive;
		logic             base_drive;
		logic             cooling_down;
		logic             override_active;
		logic [CFG_W-1:0] cooldown_left;
		logic             refused;
	} result_t;

endpackage

>>> hw/rtl/dual_pump_safety_interlock_unit.sv
// ----------------------------------------------------------------------------
// dual_pump_safety_interlock_unit
// Safety interlock for an acid and a base dosing pump.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  in      | in_valid / in_stall      | action, turn_on, is_manual
//  out     | out_valid / out_stall    | acid_drive, base_drive, cooling_down,
//          |                          | override_active, cooldown_left, refused
//  cfg     | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One event per cycle while in_stall is low. An event is held in the input
// register, the state update and result are worked out from it there, and
// the result lands in the output register. Reset clears all pump state and
// loads the default limits. in_stall rises only when both the input and the
// output register are full and out_stall is high.
// ----------------------------------------------------------------------------
module dual_pump_safety_interlock_unit import dpsi_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic               turn_on,
	input  logic               is_manual,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               acid_drive,
	output logic               base_drive,
	output logic               cooling_down,
	output logic               override_active,
	output logic [CFG_W-1:0]   cooldown_left,
	output logic               refused,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;
	logic    fire;

	// the result slot frees up when empty or being taken
	assign adv_s1   = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	dpsi_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dpsi_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.action    <= action;
			item_s1.turn_on   <= turn_on;
			item_s1.is_manual <= is_manual;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign acid_drive      = res_s2.acid_drive;
	assign base_drive      = res_s2.base_drive;
	assign cooling_down    = res_s2.cooling_down;
	assign override_active = res_s2.override_active;
	assign cooldown_left   = res_s2.cooldown_left;
	assign refused         = res_s2.refused;

endmodule

>>> hw/rtl/dpsi_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpsi_cfg_regs
// APB register file holding run limit, cooldown, override and relay polarity.
// ----------------------------------------------------------------------------
module dpsi_cfg_regs import dpsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pump_max_ticks   <= PUMP_MAX_RST;
			cfg_q.cooldown_ticks   <= COOLDOWN_RST;
			cfg_q.override_ticks   <= OVERRIDE_RST;
			cfg_q.relay_active_low <= RELAY_POL_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PUMP_MAX:  cfg_q.pump_max_ticks   <= pwdata[CFG_W-1:0];
				REG_COOLDOWN:  cfg_q.cooldown_ticks   <= pwdata[CFG_W-1:0];
				REG_OVERRIDE:  cfg_q.override_ticks   <= pwdata[CFG_W-1:0];
				REG_RELAY_POL: cfg_q.relay_active_low <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PUMP_MAX:  prdata = PDATA_W'(cfg_q.pump_max_ticks);
			REG_COOLDOWN:  prdata = PDATA_W'(cfg_q.cooldown_ticks);
			REG_OVERRIDE:  prdata = PDATA_W'(cfg_q.override_ticks);
			REG_RELAY_POL: prdata = PDATA_W'(cfg_q.relay_active_low);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/dpsi_core.sv
// ----------------------------------------------------------------------------
// dpsi_core
// Interlock state and combinational update for one event.
// ----------------------------------------------------------------------------
module dpsi_core import dpsi_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	logic                  acid_q, base_q, cool_q, ovr_q;
	logic [TIMER_BITS-1:0] run_el_q, cool_el_q, ovr_el_q;

	logic                  acid_n, base_n, cool_n, ovr_n;
	logic [TIMER_BITS-1:0] run_el_n, cool_el_n, ovr_el_n;
	logic                  refused;
	logic                  other;
	logic [CMP_W-1:0]      pmax_x, cdt_x, ovt_x, cool_el_x;
	logic [CMP_W-1:0]      left_x;

	assign pmax_x = CMP_W'(cfg.pump_max_ticks);
	assign cdt_x  = CMP_W'(cfg.cooldown_ticks);
	assign ovt_x  = CMP_W'(cfg.override_ticks);

	always_comb begin
		acid_n    = acid_q;
		base_n    = base_q;
		cool_n    = cool_q;
		ovr_n     = ovr_q;
		run_el_n  = run_el_q;
		cool_el_n = cool_el_q;
		ovr_el_n  = ovr_el_q;
		refused   = 1'b0;
		other     = 1'b0;

		case (item.action)
			ACT_TICK: begin
				// advance with saturation
				run_el_n  = (run_el_q == CNT_MAX) ? run_el_q : run_el_q + 1'b1;
				cool_el_n = (cool_el_q == CNT_MAX) ? cool_el_q : cool_el_q + 1'b1;
				ovr_el_n  = (ovr_el_q == CNT_MAX) ? ovr_el_q : ovr_el_q + 1'b1;
				if ((acid_q || base_q) && CMP_W'(run_el_n) >= pmax_x) begin
					acid_n    = 1'b0;
					base_n    = 1'b0;
					cool_n    = 1'b1;
					cool_el_n = '0;
				end
				if (cool_n && CMP_W'(cool_el_n) >= cdt_x)
					cool_n = 1'b0;
				if (ovr_q && CMP_W'(ovr_el_n) >= ovt_x)
					ovr_n = 1'b0;
			end
			ACT_ACID, ACT_BASE: begin
				if (cool_q && item.turn_on) begin
					refused = 1'b1;
				end else begin
					if (item.action == ACT_ACID) begin
						acid_n = item.turn_on;
						other  = base_q;
					end else begin
						base_n = item.turn_on;
						other  = acid_q;
					end
					if (item.turn_on) begin
						run_el_n = '0;
					end else if (!other) begin
						cool_n    = 1'b1;
						cool_el_n = '0;
					end
					if (item.is_manual) begin
						ovr_n    = 1'b1;
						ovr_el_n = '0;
					end
				end
			end
			ACT_STOP: begin
				acid_n    = 1'b0;
				base_n    = 1'b0;
				cool_n    = 1'b1;
				cool_el_n = '0;
			end
			ACT_ESTOP: begin
				acid_n    = 1'b0;
				base_n    = 1'b0;
				cool_n    = 1'b1;
				cool_el_n = '0;
				ovr_n     = 1'b0;
			end
			default: ;
		endcase
	end

	assign cool_el_x = CMP_W'(cool_el_n);
	assign left_x    = (cool_n && cool_el_x < cdt_x) ? (cdt_x - cool_el_x) : '0;

	assign res.acid_drive      = acid_n ^ cfg.relay_active_low;
	assign res.base_drive      = base_n ^ cfg.relay_active_low;
	assign res.cooling_down    = cool_n;
	assign res.override_active = ovr_n;
	assign res.cooldown_left   = left_x[CFG_W-1:0];
	assign res.refused         = refused;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acid_q    <= 1'b0;
			base_q    <= 1'b0;
			cool_q    <= 1'b0;
			ovr_q     <= 1'b0;
			run_el_q  <= '0;
			cool_el_q <= '0;
			ovr_el_q  <= '0;
		end else if (fire) begin
			acid_q    <= acid_n;
			base_q    <= base_n;
			cool_q    <= cool_n;
			ovr_q     <= ovr_n;
			run_el_q  <= run_el_n;
			cool_el_q <= cool_el_n;
			ovr_el_q  <= ovr_el_n;
		end
	end

endmodule

>>> dv/dpsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsi_checker
// Watches the event, result and register channels of the pump interlock. It
// keeps its own copy of the limits and the pump state, works out the result
// of every accepted event and compares each delivered result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module dpsi_checker import dpsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic               turn_on,
	input  logic               is_manual,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               acid_drive,
	input  logic               base_drive,
	input  logic               cooling_down,
	input  logic               override_active,
	input  logic [CFG_W-1:0]   cooldown_left,
	input  logic               refused,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 refusals
);

	localparam int TW = TIMER_BITS_DEF;

	// limits as last written
	logic [CFG_W-1:0] lim_run;
	logic [CFG_W-1:0] lim_cool;
	logic [CFG_W-1:0] lim_ovr;
	logic             relay_pol;

	// pump state
	logic          acid_on;
	logic          base_on;
	logic          cool_act;
	logic          ovr_act;
	logic [TW-1:0] run_cnt;
	logic [TW-1:0] cool_cnt;
	logic [TW-1:0] ovr_cnt;

	result_t drive_q[$];
	result_t want;
	result_t seen;
	item_t   evt;

	function automatic logic [TW-1:0] sat_inc(logic [TW-1:0] v);
		return (v == {TW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic void halt_pumps();
		acid_on  = 1'b0;
		base_on  = 1'b0;
		cool_act = 1'b1;
		cool_cnt = '0;
	endfunction

	// Advance the interlock by one event and return the result it reports.
	function automatic result_t step_interlock(item_t it);
		result_t r;
		logic    blocked;
		logic    other;
		blocked = 1'b0;
		case (it.action)
			ACT_TICK: begin
				run_cnt  = sat_inc(run_cnt);
				cool_cnt = sat_inc(cool_cnt);
				ovr_cnt  = sat_inc(ovr_cnt);
				if ((acid_on || base_on) && run_cnt >= lim_run)
					halt_pumps();
				if (cool_act && cool_cnt >= lim_cool)
					cool_act = 1'b0;
				if (ovr_act && ovr_cnt >= lim_ovr)
					ovr_act = 1'b0;
			end
			ACT_ACID, ACT_BASE: begin
				if (cool_act && it.turn_on) begin
					// refused switch-on: drop the whole command, manual flag included
					blocked = 1'b1;
				end else begin
					if (it.action == ACT_ACID) begin
						acid_on = it.turn_on;
						other   = base_on;
					end else begin
						base_on = it.turn_on;
						other   = acid_on;
					end
					if (it.turn_on) begin
						run_cnt = '0;
					end else if (!other) begin
						cool_act = 1'b1;
						cool_cnt = '0;
					end
					if (it.is_manual) begin
						ovr_act = 1'b1;
						ovr_cnt = '0;
					end
				end
			end
			ACT_STOP: begin
				halt_pumps();
			end
			ACT_ESTOP: begin
				halt_pumps();
				ovr_act = 1'b0;
			end
			default: begin
			end
		endcase
		r.acid_drive      = acid_on ^ relay_pol;
		r.base_drive      = base_on ^ relay_pol;
		r.cooling_down    = cool_act;
		r.override_active = ovr_act;
		r.cooldown_left   = (cool_act && cool_cnt < lim_cool) ? lim_cool - cool_cnt : '0;
		r.refused         = blocked;
		return r;
	endfunction

	function automatic void check_field(string name, logic [CFG_W-1:0] exp_v,
			logic [CFG_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_run    = PUMP_MAX_RST;
			lim_cool   = COOLDOWN_RST;
			lim_ovr    = OVERRIDE_RST;
			relay_pol  = RELAY_POL_RST;
			acid_on    = 1'b0;
			base_on    = 1'b0;
			cool_act   = 1'b0;
			ovr_act    = 1'b0;
			run_cnt    = '0;
			cool_cnt   = '0;
			ovr_cnt    = '0;
			drive_q.delete();
			mismatches = 0;
			pending    = 0;
			checked    = 0;
			refusals   = 0;
		end else begin
			// compare first: a result leaving now belongs to an older event
			if (out_valid && !out_stall) begin
				seen.acid_drive      = acid_drive;
				seen.base_drive      = base_drive;
				seen.cooling_down    = cooling_down;
				seen.override_active = override_active;
				seen.cooldown_left   = cooldown_left;
				seen.refused         = refused;
				checked++;
				if (drive_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with no event waiting, actual %0h", $time, seen);
				end else begin
					want = drive_q.pop_front();
					if (want.refused)
						refusals++;
					check_field("acid_drive", want.acid_drive, seen.acid_drive);
					check_field("base_drive", want.base_drive, seen.base_drive);
					check_field("cooling_down", want.cooling_down, seen.cooling_down);
					check_field("override_active", want.override_active,
						seen.override_active);
					check_field("cooldown_left", want.cooldown_left, seen.cooldown_left);
					check_field("refused", want.refused, seen.refused);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_PUMP_MAX:  lim_run   = pwdata[CFG_W-1:0];
					REG_COOLDOWN:  lim_cool  = pwdata[CFG_W-1:0];
					REG_OVERRIDE:  lim_ovr   = pwdata[CFG_W-1:0];
					REG_RELAY_POL: relay_pol = pwdata[0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				evt.action    = action;
				evt.turn_on   = turn_on;
				evt.is_manual = is_manual;
				drive_q.push_back(step_interlock(evt));
			end
			pending = drive_q.size();
		end
	end

endmodule

>>> dv/dual_pump_safety_interlock_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pump_safety_interlock_unit_test
// Drives pump events and limit settings into the interlock, with random gaps
// and back-pressure, and one long output hold that fills the block. The
// checker beside the block predicts every result; this module gives the
// verdict from its mismatch and pending counts.
// ----------------------------------------------------------------------------
module dual_pump_safety_interlock_unit_test;
	import dpsi_pkg::*;

	localparam int LATENCY        = 2;
	localparam int HOLD_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 500;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [ACT_W-1:0]   action = ACT_TICK;
	logic               turn_on = 1'b0;
	logic               is_manual = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               acid_drive;
	logic               base_drive;
	logic               cooling_down;
	logic               override_active;
	logic [CFG_W-1:0]   cooldown_left;
	logic               refused;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int pending;
	int checked;
	int refusals;

	logic idle_en = 1'b1;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   stall_burst = 0;
	int   quiet_cycles = 0;
	int   events_sent = 0;
	int   settings = 0;

	dual_pump_safety_interlock_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.turn_on         (turn_on),
		.is_manual       (is_manual),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.acid_drive      (acid_drive),
		.base_drive      (base_drive),
		.cooling_down    (cooling_down),
		.override_active (override_active),
		.cooldown_left   (cooldown_left),
		.refused         (refused),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	dpsi_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.turn_on         (turn_on),
		.is_manual       (is_manual),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.acid_drive      (acid_drive),
		.base_drive      (base_drive),
		.cooling_down    (cooling_down),
		.override_active (override_active),
		.cooldown_left   (cooldown_left),
		.refused         (refused),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.pending         (pending),
		.checked         (checked),
		.refusals        (refusals)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: short random stall bursts, plus one long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_burst = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_event(input item_t it);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action    <= it.action;
		turn_on   <= it.turn_on;
		is_manual <= it.is_manual;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		events_sent++;
	endtask

	task automatic send(input logic [ACT_W-1:0] a, input logic on, input logic man);
		item_t it;
		it.action    = a;
		it.turn_on   = on;
		it.is_manual = man;
		send_event(it);
	endtask

	function automatic item_t pick_event();
		item_t it;
		int    roll;
		roll = $urandom_range(0, 99);
		if (roll < 42)
			it.action = ACT_TICK;
		else if (roll < 64)
			it.action = ACT_ACID;
		else if (roll < 86)
			it.action = ACT_BASE;
		else if (roll < 92)
			it.action = ACT_STOP;
		else if (roll < 96)
			it.action = ACT_ESTOP;
		else
			it.action = ACT_W'($urandom_range(5, 7));
		it.turn_on   = 1'($urandom_range(0, 1));
		it.is_manual = ($urandom_range(0, 3) == 0);
		return it;
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_event(pick_event());
	endtask

	// Lower valid, wait for every result, then give the pipeline time to settle.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Unused upper data bits carry noise; the block must mask them.
	task automatic program_limits(input logic [CFG_W-1:0] run_lim,
			input logic [CFG_W-1:0] cool_lim, input logic [CFG_W-1:0] ovr_lim,
			input logic pol);
		write_reg(REG_PUMP_MAX, {8'($urandom), run_lim});
		write_reg(REG_COOLDOWN, {8'($urandom), cool_lim});
		write_reg(REG_OVERRIDE, {8'($urandom), ovr_lim});
		write_reg(REG_RELAY_POL, {31'($urandom), pol});
		settings++;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// power-on limits
		settings = 1;
		send_random(30);
		drain_block();

		program_limits(24'd3, 24'd2, 24'd4, 1'b0);
		send(ACT_ACID, 1'b1, 1'b1);
		send(ACT_BASE, 1'b1, 1'b0);
		repeat (3) send(ACT_TICK, 1'b0, 1'b0);   // third tick hits the run limit
		send(ACT_ACID, 1'b1, 1'b1);              // refused during cooldown
		send(ACT_BASE, 1'b1, 1'b0);              // refused during cooldown
		send(ACT_ACID, 1'b0, 1'b0);              // switch-off still allowed
		send(ACT_TICK, 1'b1, 1'b1);              // override expires
		send(ACT_TICK, 1'b0, 1'b0);
		send(ACT_TICK, 1'b0, 1'b0);
		send(ACT_ACID, 1'b1, 1'b0);
		send(ACT_BASE, 1'b1, 1'b1);
		send(ACT_ACID, 1'b0, 1'b0);              // base still on: no cooldown
		send(ACT_BASE, 1'b0, 1'b0);              // both off: cooldown
		send(ACT_TICK, 1'b0, 1'b0);
		send(ACT_TICK, 1'b0, 1'b0);
		send(ACT_BASE, 1'b1, 1'b1);
		send(ACT_STOP, 1'b1, 1'b1);
		send(ACT_ESTOP, 1'b1, 1'b1);
		send(ACT_W'(5), 1'b1, 1'b1);
		send(ACT_W'(6), 1'b0, 1'b1);
		send(ACT_W'(7), 1'b1, 1'b0);
		drain_block();

		program_limits('0, '0, '0, 1'b1);
		send_random(70);
		drain_block();

		program_limits({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, 1'b0);
		send_random(70);
		drain_block();

		for (int ph = 0; ph < 4; ph++) begin
			program_limits(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 8)),
				CFG_W'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
			if (ph == 1)
				hold_req = 1'b1;
			send_random(90);
			drain_block();
		end

		// closing stretch at full rate
		idle_en = 1'b0;
		program_limits(24'd5, 24'd3, 24'd6, 1'b1);
		send_random(100);
		drain_block();

		$display("Sent %0d events over %0d limit settings; %0d results checked, %0d refusals.",
			events_sent, settings, checked, refusals);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dpsi_pkg.sv
hw/rtl/dpsi_cfg_regs.sv
hw/rtl/dpsi_core.sv
hw/rtl/dual_pump_safety_interlock_unit.sv
dv/dpsi_checker.sv
dv/dual_pump_safety_interlock_unit_test.sv
